// ===== src/pllm_pkg.sv =====
// Shared types, constants and command codes for the pooled linked list manager.
`default_nettype none
package pllm_pkg;

    // Pool geometry; entry 0 is the null mark.
    localparam int POOL_SIZE = 256;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    // Stream widths.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_WB
    } state_t;

    // Write port of a link memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } link_wr_t;

    // Write port of the allocated-flag memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic             data;
    } flag_wr_t;

    // Read request: next memory reads next_addr, prev and flag memories read node_addr.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] next_addr;
        logic [IDX_W-1:0] node_addr;
    } rd_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] result_index;
        logic [7:0] next_of_node;
        logic [7:0] prev_of_node;
        logic [7:0] head_index;
    } result_t;

endpackage
`default_nettype wire

// ===== src/pllm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pllm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/pllm_ctrl.sv =====
// Command sequencer: clearing pass, link memory read-modify-write, head registers.
`default_nettype none
module pllm_ctrl
    import pllm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       cmd_in,
    input  wire logic [7:0]       idx_in,
    output rd_req_t               rd_req,
    input  wire logic [IDX_W-1:0] next_rd,
    input  wire logic [IDX_W-1:0] prev_rd,
    input  wire logic             alloc_rd,
    output link_wr_t              next_wr,
    output link_wr_t              prev_wr,
    output flag_wr_t              alloc_wr,
    input  wire logic             out_free,
    output logic                  res_valid,
    output result_t               res
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [IDX_W-1:0] list_head_reg, list_head_next;
    logic [IDX_W-1:0] fh_old_reg, fh_old_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [7:0]       idx_reg, idx_next;

    logic             in_fire;
    logic [IDX_W-1:0] cur;
    logic             in_range;
    logic             live;
    logic [1:0]       status_c;
    logic             mod_ok;
    logic             advance;
    logic [IDX_W-1:0] head_after;
    logic [IDX_W-1:0] init_next;

    assign in_fire = in_valid && in_ready;

    // Decode of the held command against the registered read data.
    always_comb
    begin
        cur      = IDX_W'(idx_reg);
        in_range = (32'(idx_reg) < POOL_SIZE);
        live     = (idx_reg != 8'd0) && in_range && alloc_rd;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (free_head_reg == '0)
                    status_c = STAT_FULL;
                else if ((idx_reg != 8'd0) && !live)
                    status_c = STAT_BAD;
                else
                    status_c = STAT_OK;
            end
            CMD_DELETE: status_c = live ? STAT_OK : STAT_BAD;
            CMD_QUERY:  status_c = live ? STAT_OK : STAT_BAD;
            default:    status_c = STAT_BAD;
        endcase
        mod_ok  = (status_c == STAT_OK) && ((cmd_reg == CMD_INSERT) || (cmd_reg == CMD_DELETE));
        advance = (state_reg == S_EXEC) && out_free;

        head_after = list_head_reg;
        if (mod_ok && (cmd_reg == CMD_INSERT) && (list_head_reg == cur))
            head_after = free_head_reg;
        if (mod_ok && (cmd_reg == CMD_DELETE) && (list_head_reg == cur))
            head_after = next_rd;

        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        fh_old_next    = fh_old_reg;
        if (advance)
        begin
            list_head_next = head_after;
            fh_old_next    = free_head_reg;
            if (mod_ok)
                free_head_next = (cmd_reg == CMD_INSERT) ? next_rd : cur;
        end

        cmd_next = in_fire ? cmd_in : cmd_reg;
        idx_next = in_fire ? idx_in : idx_reg;

        // Reset image of next_link: chain 2..last, entries 0, 1 and last hold null.
        init_next = ((clr_cnt_reg >= IDX_W'(2)) && (clr_cnt_reg != LAST_IDX))
                  ? clr_cnt_reg + IDX_W'(1) : '0;
        clr_cnt_next = (state_reg == S_INIT) ? clr_cnt_reg + IDX_W'(1) : clr_cnt_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
                if (clr_cnt_reg == LAST_IDX)
                    state_next = S_IDLE;
            S_IDLE:
                if (in_fire)
                    state_next = S_EXEC;
            S_EXEC:
                if (out_free)
                    state_next = mod_ok ? S_WB : S_IDLE;
            S_WB:
                state_next = S_IDLE;
            default:
                state_next = S_INIT;
        endcase
    end

    // Outputs: memory ports and result.
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        rd_req    = '{en: in_fire,
                      next_addr: (cmd_in == CMD_INSERT) ? free_head_reg : IDX_W'(idx_in),
                      node_addr: IDX_W'(idx_in)};
        next_wr   = '0;
        prev_wr   = '0;
        alloc_wr  = '0;
        res_valid = 1'b0;
        res       = '{status: status_c, result_index: 8'd0, next_of_node: 8'd0,
                      prev_of_node: 8'd0, head_index: 8'(head_after)};
        case (state_reg)
            S_INIT:
            begin
                next_wr  = '{we: 1'b1, addr: clr_cnt_reg, data: init_next};
                prev_wr  = '{we: 1'b1, addr: clr_cnt_reg, data: '0};
                alloc_wr = '{we: 1'b1, addr: clr_cnt_reg, data: (clr_cnt_reg == IDX_W'(1))};
            end
            S_EXEC:
            begin
                res_valid = out_free;
                if (status_c == STAT_OK)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            res.result_index = 8'(free_head_reg);
                            res.next_of_node = idx_reg;
                            res.prev_of_node = (cur != '0) ? 8'(prev_rd) : 8'd0;
                            next_wr  = '{we: out_free, addr: free_head_reg, data: cur};
                            prev_wr  = '{we: out_free, addr: free_head_reg,
                                         data: (cur != '0) ? prev_rd : '0};
                            alloc_wr = '{we: out_free, addr: free_head_reg, data: 1'b1};
                        end
                        CMD_DELETE:
                        begin
                            res.result_index = idx_reg;
                            prev_wr  = '{we: out_free && (next_rd != '0), addr: next_rd,
                                         data: prev_rd};
                            next_wr  = '{we: out_free && (prev_rd != '0), addr: prev_rd,
                                         data: next_rd};
                            alloc_wr = '{we: out_free, addr: cur, data: 1'b0};
                        end
                        default:
                        begin
                            res.result_index = idx_reg;
                            res.next_of_node = 8'(next_rd);
                            res.prev_of_node = 8'(prev_rd);
                        end
                    endcase
                end
            end
            S_WB:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    // Splice the new node in: predecessor's next, cursor's prev.
                    next_wr = '{we: (cur != '0) && (prev_rd != '0), addr: prev_rd,
                                data: fh_old_reg};
                    prev_wr = '{we: (cur != '0), addr: cur, data: fh_old_reg};
                end
                else
                begin
                    // Freed node joins the free list.
                    next_wr = '{we: 1'b1, addr: cur, data: fh_old_reg};
                    prev_wr = '{we: 1'b1, addr: cur, data: '0};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_cnt_reg   <= '0;
            free_head_reg <= IDX_W'(2);
            list_head_reg <= IDX_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        fh_old_reg <= fh_old_next;
    end

    a_res_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result issued while output slot occupied");

    a_wb_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> ($past(state_reg) == S_EXEC))
        else $error("write-back not preceded by execute");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(next_wr.we || prev_wr.we || alloc_wr.we))
        else $error("memory write while idle");

    a_read_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        rd_req.en |=> (state_reg == S_EXEC))
        else $error("read data not consumed in execute");

endmodule
`default_nettype wire

// ===== src/pooled_linked_list_manager.sv =====
// Top level of the pooled linked list manager: link memories, sequencer, output register.
//
// Usage:
//   Commands arrive on the s_ stream, one per transfer: insert before a cursor
//   node, delete a node, or query a node's links. Each command produces exactly
//   one result transfer on the m_ stream with status, node index, its next and
//   prev links after the command, and the list head after the command.
//   Sequence: reads issue at the command transfer, and the execute state that
//   follows uses the registered read data and loads the output register.
//   An insert or delete that succeeds then passes through a write-back state
//   for the next and prev link memories, which have one write port each.
//   A new command is taken only in the idle state, so commands do not overlap:
//   the read-execute-writeback sequence on the link memories sets the pace.
//   Reset: after rst_n rises, a clearing pass writes the initial pool image
//   (one node allocated as the list head, the rest chained as free list) over
//   all POOL_SIZE entries, one per cycle; s_tready stays low throughout the
//   clearing pass.
//   Stall: the result sits in a one-deep output register. A new command is
//   still taken while it waits; its execution holds until the register frees.
`default_nettype none
module pooled_linked_list_manager
    import pllm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // command[1:0], node_index[9:2], zero fill
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata    // status[1:0], result_index[9:2],
                                                // next_of_node[17:10], prev_of_node[25:18],
                                                // head_index[33:26], zero fill
);

    rd_req_t          rd_req;
    link_wr_t         next_wr;
    link_wr_t         prev_wr;
    flag_wr_t         alloc_wr;
    logic [IDX_W-1:0] next_rd;
    logic [IDX_W-1:0] prev_rd;
    logic             alloc_rd;
    logic             out_free;
    logic             res_valid;
    result_t          res;

    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg, m_data_next;

    // next_link memory
    pllm_ram #(
        .DATA_W (IDX_W),
        .DEPTH  (POOL_SIZE),
        .ADDR_W (IDX_W)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_wr.we),
        .waddr (next_wr.addr),
        .wdata (next_wr.data),
        .re    (rd_req.en),
        .raddr (rd_req.next_addr),
        .rdata (next_rd)
    );

    // prev_link memory
    pllm_ram #(
        .DATA_W (IDX_W),
        .DEPTH  (POOL_SIZE),
        .ADDR_W (IDX_W)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_wr.we),
        .waddr (prev_wr.addr),
        .wdata (prev_wr.data),
        .re    (rd_req.en),
        .raddr (rd_req.node_addr),
        .rdata (prev_rd)
    );

    // allocated flags
    pllm_ram #(
        .DATA_W (1),
        .DEPTH  (POOL_SIZE),
        .ADDR_W (IDX_W)
    ) u_alloc_ram (
        .clk   (clk),
        .we    (alloc_wr.we),
        .waddr (alloc_wr.addr),
        .wdata (alloc_wr.data),
        .re    (rd_req.en),
        .raddr (rd_req.node_addr),
        .rdata (alloc_rd)
    );

    pllm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd_in    (s_tdata[1:0]),
        .idx_in    (s_tdata[9:2]),
        .rd_req    (rd_req),
        .next_rd   (next_rd),
        .prev_rd   (prev_rd),
        .alloc_rd  (alloc_rd),
        .next_wr   (next_wr),
        .prev_wr   (prev_wr),
        .alloc_wr  (alloc_wr),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free)
        begin
            m_valid_next = res_valid;
            if (res_valid)
                m_data_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg.head_index, m_data_reg.prev_of_node,
                       m_data_reg.next_of_node, m_data_reg.result_index,
                       m_data_reg.status};

endmodule
`default_nettype wire

// ===== tb/sv/tb_pooled_linked_list_manager.sv =====
// Testbench for the pooled linked list manager: streamed commands checked against a link-pool predictor.
`timescale 1ns / 100ps

module tb_pooled_linked_list_manager;
    import pllm_pkg::*;

    // Command 3 has no package name; the block must reject it.
    localparam logic [1:0] CMD_UNDEF = 2'd3;

    // Two copies of the pool image: one advanced while the command list is built,
    // so that the list can aim at live nodes, and one advanced on accepted transfers.
    localparam int PLAN_POOL  = 0;
    localparam int CHECK_POOL = 1;

    // Flavors of a random command run.
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_NOISE  = 2;

    localparam int N_ITEMS     = 1550;
    localparam int QUIET_LIMIT = 5000;   // covers the clearing pass and long stalls

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    pooled_linked_list_manager u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pool images, indexed by copy then node.
    logic [7:0] next_of  [2][256];
    logic [7:0] prev_of  [2][256];
    logic       in_use   [2][256];
    logic [7:0] free_top [2];
    logic [7:0] list_top [2];

    logic [9:0] cmd_queue[$];       // {node_index, command} still to be sent
    result_t    link_results[$];    // results owed by the block, oldest first
    int         n_accepted = 0;
    int         n_errors   = 0;
    int         quiet      = 0;
    int         gap_pct;
    int         stall_pct;

    // Image after reset: node 1 is the only list member, nodes 2 up form the free chain.
    task automatic reset_pool(input int c);
        int i;
        for (i = 0; i < 256; i++)
        begin
            next_of[c][i] = (i >= 2 && i < 255) ? 8'(i + 1) : 8'd0;
            prev_of[c][i] = 8'd0;
            in_use[c][i]  = 1'b0;
        end
        in_use[c][1] = 1'b1;
        free_top[c]  = 8'd2;
        list_top[c]  = 8'd1;
    endtask

    // Applies one command to pool copy c and returns the result it owes.
    function automatic result_t run_command(input int c, input logic [1:0] cmd,
                                            input logic [7:0] idx);
        result_t    r;
        logic [7:0] fresh;
        logic [7:0] nx;
        logic [7:0] pv;
        logic       live;
        r    = '0;
        live = (idx != 8'd0) && in_use[c][idx];
        r.status = STAT_BAD;
        case (cmd)
            CMD_INSERT:
            begin
                if (free_top[c] == 8'd0)
                    r.status = STAT_FULL;
                else if (idx == 8'd0 || live)
                begin
                    fresh          = free_top[c];
                    free_top[c]    = next_of[c][fresh];
                    in_use[c][fresh]  = 1'b1;
                    next_of[c][fresh] = idx;
                    if (idx != 8'd0)
                    begin
                        pv = prev_of[c][idx];
                        prev_of[c][fresh] = pv;
                        if (pv != 8'd0)
                            next_of[c][pv] = fresh;
                        prev_of[c][idx] = fresh;
                    end
                    else
                        prev_of[c][fresh] = 8'd0;
                    // cursor 0 only takes the head when the list is empty
                    if (list_top[c] == idx)
                        list_top[c] = fresh;
                    r.status       = STAT_OK;
                    r.result_index = fresh;
                    r.next_of_node = next_of[c][fresh];
                    r.prev_of_node = prev_of[c][fresh];
                end
            end
            CMD_DELETE:
            begin
                if (live)
                begin
                    nx = next_of[c][idx];
                    pv = prev_of[c][idx];
                    if (list_top[c] == idx)
                        list_top[c] = nx;
                    if (nx != 8'd0)
                        prev_of[c][nx] = pv;
                    if (pv != 8'd0)
                        next_of[c][pv] = nx;
                    next_of[c][idx] = free_top[c];
                    prev_of[c][idx] = 8'd0;
                    free_top[c]     = idx;
                    in_use[c][idx]  = 1'b0;
                    r.status        = STAT_OK;
                    r.result_index  = idx;   // freed node reports null links
                end
            end
            CMD_QUERY:
            begin
                if (live)
                begin
                    r.status       = STAT_OK;
                    r.result_index = idx;
                    r.next_of_node = next_of[c][idx];
                    r.prev_of_node = prev_of[c][idx];
                end
            end
            default: ;
        endcase
        r.head_index = list_top[c];
        return r;
    endfunction

    // Random node that the planning copy holds allocated (want=1) or free (want=0);
    // 0 when there is none.
    function automatic logic [7:0] pick_node(input logic want);
        int         start;
        int         k;
        logic [7:0] j;
        start = $urandom_range(1, 255);
        for (k = 0; k < 255; k++)
        begin
            j = 8'(1 + (start - 1 + k) % 255);
            if (in_use[PLAN_POOL][j] == want)
                return j;
        end
        return 8'd0;
    endfunction

    // Insert cursor: mostly a live node, sometimes null, sometimes anything.
    function automatic logic [7:0] pick_cursor();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'd0;
        if (r < 18)
            return 8'($urandom_range(0, 255));
        return pick_node(1'b1);
    endfunction

    task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] idx);
        result_t discard;
        cmd_queue.push_back({idx, cmd});
        discard = run_command(PLAN_POOL, cmd, idx);
    endtask

    task automatic queue_run(input int mode, input int count);
        int          n;
        int unsigned r;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            case (mode)
                MODE_GROW:
                    if (r < 75)
                        queue_cmd(CMD_INSERT, pick_cursor());
                    else if (r < 88)
                        queue_cmd(CMD_QUERY, pick_node(1'b1));
                    else
                        queue_cmd(CMD_DELETE, pick_node(1'b1));
                MODE_SHRINK:
                    if (r < 70)
                        queue_cmd(CMD_DELETE, pick_node(1'b1));
                    else if (r < 80)
                        queue_cmd(CMD_QUERY, pick_node(1'b1));
                    else if (r < 88)
                        queue_cmd(CMD_QUERY, pick_node(1'b0));
                    else
                        queue_cmd(CMD_INSERT, pick_cursor());
                default:
                    queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Grow until the free chain runs dry, poke at the full pool, then empty the list.
    task automatic queue_fill_drain();
        int k;
        while (free_top[PLAN_POOL] != 8'd0)
            queue_cmd(CMD_INSERT, pick_cursor());
        for (k = 0; k < 4; k++)
            queue_cmd(CMD_INSERT, 8'($urandom_range(0, 255)));
        queue_cmd(CMD_QUERY, 8'd255);
        while (pick_node(1'b1) != 8'd0)
        begin
            if ($urandom_range(0, 99) < 20)
                queue_cmd(CMD_QUERY, pick_node(1'b1));
            queue_cmd(CMD_DELETE, pick_node(1'b1));
        end
        queue_cmd(CMD_DELETE, 8'($urandom_range(1, 255)));
    endtask

    // Idling by phase: none, sender gaps, receiver stalls, then both.
    always_comb
    begin
        gap_pct   = 0;
        stall_pct = 0;
        if (n_accepted >= 400 && n_accepted < 800)
            gap_pct = 67;
        else if (n_accepted >= 800 && n_accepted < 1200)
            stall_pct = 67;
        else if (n_accepted >= 1200)
        begin
            gap_pct   = 37;
            stall_pct = 37;
        end
    end

    // Driver: predicts on each accepted transfer, then offers the next command.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                link_results.push_back(run_command(CHECK_POOL, s_tdata[1:0], s_tdata[9:2]));
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    s_tdata  <= S_DATA_W'(cmd_queue.pop_front());
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest owed result.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status       = m_tdata[1:0];
                got.result_index = m_tdata[9:2];
                got.next_of_node = m_tdata[17:10];
                got.prev_of_node = m_tdata[25:18];
                got.head_index   = m_tdata[33:26];
                if (link_results.size() == 0)
                begin
                    $display("%0t: unexpected result st=%0d node=%0d next=%0d prev=%0d head=%0d",
                             $time, got.status, got.result_index, got.next_of_node,
                             got.prev_of_node, got.head_index);
                    n_errors++;
                end
                else
                begin
                    want = link_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected st=%0d node=%0d next=%0d prev=%0d head=%0d",
                                 $time, want.status, want.result_index, want.next_of_node,
                                 want.prev_of_node, want.head_index);
                        $display("%0t: actual   st=%0d node=%0d next=%0d prev=%0d head=%0d",
                                 $time, got.status, got.result_index, got.next_of_node,
                                 got.prev_of_node, got.head_index);
                        n_errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: too many cycles without a transfer on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("pooled_linked_list_manager: mismatch");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        int seg;
        reset_pool(PLAN_POOL);
        reset_pool(CHECK_POOL);

        // Directed: a query of the initial head, then rejects, then build a short list and take it apart.
        queue_cmd(CMD_QUERY,  8'd1);     // initial head
        queue_cmd(CMD_QUERY,  8'd0);     // null target
        queue_cmd(CMD_QUERY,  8'hFF);    // never allocated
        queue_cmd(CMD_DELETE, 8'd0);
        queue_cmd(CMD_DELETE, 8'hAA);
        queue_cmd(CMD_UNDEF,  8'd1);     // unknown command on a live node
        queue_cmd(CMD_UNDEF,  8'h55);
        queue_cmd(CMD_INSERT, 8'd1);     // before the head: new head
        queue_cmd(CMD_INSERT, 8'd1);     // before a node with a predecessor
        queue_cmd(CMD_INSERT, 8'd0);     // unlinked node, list not empty
        queue_cmd(CMD_INSERT, 8'hAA);    // bad cursor
        queue_cmd(CMD_QUERY,  8'd3);
        queue_cmd(CMD_QUERY,  8'd4);
        queue_cmd(CMD_QUERY,  8'd2);
        queue_cmd(CMD_DELETE, 8'd3);     // middle
        queue_cmd(CMD_DELETE, 8'd2);     // head
        queue_cmd(CMD_DELETE, 8'd1);     // last member: list empty
        queue_cmd(CMD_INSERT, 8'd0);     // null cursor on empty list takes the head
        queue_cmd(CMD_DELETE, 8'd4);     // the unlinked node
        queue_cmd(CMD_QUERY,  8'd4);     // freed
        queue_cmd(CMD_INSERT, 8'h55);
        queue_cmd(CMD_DELETE, 8'd1);
        queue_cmd(CMD_QUERY,  8'd1);

        // Random runs, with two full fill-and-drain passes to reach the full pool.
        seg = 0;
        while (cmd_queue.size() < N_ITEMS)
        begin
            if (seg == 2 || seg == 7)
                queue_fill_drain();
            else
                queue_run($urandom_range(MODE_GROW, MODE_NOISE), $urandom_range(40, 120));
            seg++;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || s_tvalid || link_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (n_errors == 0 && link_results.size() == 0)
            $display("pooled_linked_list_manager: match");
        else
            $display("pooled_linked_list_manager: mismatch");
        $finish;
    end

endmodule
